/* rtl/core/hndq_pkg.sv */
// Shared types and constants of the humanised note delay queue.
package hndq_pkg;

    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int COL_W    = 6;
    localparam int SMP_W    = 8;
    localparam int LEN_W    = 16;
    localparam int DRAW_W   = 32;
    localparam int VSPR_W   = 7;
    localparam int TSPR_W   = 10;
    localparam int MOD_W    = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_ADVANCE  = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;

    localparam logic [ADDR_W-1:0] REG_VEL_SPREAD = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TIM_SPREAD = 3'd4;

    localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

    typedef struct packed {
        logic [1:0]        command;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  note_velocity;
        logic [COL_W-1:0]  column_id;
        logic [SMP_W-1:0]  sample_slot;
        logic [LEN_W-1:0]  row_length;
        logic [LEN_W-1:0]  frame_count;
        logic [DRAW_W-1:0] velocity_draw;
        logic [DRAW_W-1:0] delay_draw;
    } t_in;

    typedef struct packed {
        logic [NOTE_W-1:0] fired_note;
        logic [VEL_W-1:0]  fired_velocity;
        logic [COL_W-1:0]  fired_column;
        logic [SMP_W-1:0]  fired_sample;
        logic              last_of_run;
    } t_out;

endpackage

/* rtl/core/hndq_mod.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module hndq_mod (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [hndq_pkg::DRAW_W-1:0]      i_dividend,
    input  logic [hndq_pkg::MOD_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [hndq_pkg::MOD_W-1:0]       o_rem
);
    localparam int CW = $clog2(hndq_pkg::DRAW_W);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [hndq_pkg::DRAW_W-1:0]   r_quo, n_quo;
    logic [hndq_pkg::MOD_W-1:0]    r_div, n_div;
    logic [hndq_pkg::MOD_W-1:0]    r_rem, n_rem;
    logic [hndq_pkg::MOD_W:0]      trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_div  = r_div;
        n_rem  = r_rem;
        trial  = {r_rem, r_quo[hndq_pkg::DRAW_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the trial fits one extra bit.
            if (trial >= {1'b0, r_div}) begin
                n_rem = hndq_pkg::MOD_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[hndq_pkg::MOD_W-1:0];
            end
            n_quo = {r_quo[hndq_pkg::DRAW_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(hndq_pkg::DRAW_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* rtl/core/humanized_note_delay_queue.sv */
// Humanised note delay queue: slot memory, command sequencer and register port.
//
// Words arrive on i_valid/o_ready with payload i_item and leave on o_valid/i_ready
// with payload o_item; each accepted word may fire zero or more notes, and the
// last note of a word carries last_of_run. The APB port holds velocity_spread at
// address 0 and timing_spread_ms at address 4; pready is always high.
// A cancel finishes in its accepting cycle. A schedule passes the random draw
// of each active spread through a bit-serial remainder unit that handles one
// dividend bit per cycle; a note that fires at once adds a closing step. An
// advance, after its accepting cycle, walks every slot in order: an occupied
// slot takes a slot memory read and then a step to decide and write back, an
// empty slot only the read step, and a closing step follows.
// A new word is taken only once the previous one has finished.
// Fired notes pass through a one-word hold stage and an output register, so
// a stalled receiver holds the sequencer only when both are full.
// Reset empties every slot and clears both spreads; no clearing pass is needed,
// as the occupancy bits live in flip-flops.
module humanized_note_delay_queue #(
    parameter int PENDING_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hndq_pkg::t_in                   i_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hndq_pkg::t_out                  o_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hndq_pkg::ADDR_W-1:0]     paddr,
    input  logic [hndq_pkg::DATA_W-1:0]     pwdata,
    output logic [hndq_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    typedef struct packed {
        logic [hndq_pkg::NOTE_W-1:0] note;
        logic [hndq_pkg::VEL_W-1:0]  vel;
        logic [hndq_pkg::SMP_W-1:0]  smp;
        logic [hndq_pkg::LEN_W-1:0]  delay;
    } t_entry;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_VMOD = 7'b0000010,
        ST_DMOD = 7'b0000100,
        ST_ARD  = 7'b0001000,
        ST_AEV  = 7'b0010000,
        ST_AEND = 7'b0100000,
        ST_SPARE = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    hndq_pkg::t_in                   r_item, n_item;
    logic [hndq_pkg::VEL_W-1:0]      r_vel, n_vel;
    logic [SW-1:0]                   r_slot, n_slot;
    logic [PENDING_SLOTS-1:0]        r_act, n_act;
    logic [hndq_pkg::COL_W-1:0]      r_col [PENDING_SLOTS];
    logic [hndq_pkg::COL_W-1:0]      n_col [PENDING_SLOTS];
    hndq_pkg::t_out                  r_pend, n_pend;
    logic                            r_pend_vld, n_pend_vld;
    hndq_pkg::t_out                  r_out, n_out;
    logic                            r_out_vld, n_out_vld;
    logic [hndq_pkg::VSPR_W-1:0]     r_vspread;
    logic [hndq_pkg::TSPR_W-1:0]     r_tspread;

    t_entry                          mem [PENDING_SLOTS];
    t_entry                          r_rd;
    logic                            mem_we, mem_re;
    logic [SW-1:0]                   mem_wa;
    t_entry                          mem_wd;

    logic                            mod_start, mod_done;
    logic [hndq_pkg::DRAW_W-1:0]     mod_dvd;
    logic [hndq_pkg::MOD_W-1:0]      mod_dvs, mod_rem;

    hndq_pkg::t_in                   cur;
    logic                            accept, out_free, go_t, fire, found, last_slot;
    logic [hndq_pkg::VEL_W-1:0]      vel_t;
    logic signed [9:0]               vsum;
    logic [hndq_pkg::MOD_W-1:0]      maxd, half_row, dly;
    logic [SW-1:0]                   free_idx;
    logic [hndq_pkg::COL_W-1:0]      fire_col;

    hndq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (mod_dvs),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Register port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vspread <= '0;
            r_tspread <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == hndq_pkg::REG_TIM_SPREAD[2]) begin
                r_tspread <= pwdata[hndq_pkg::TSPR_W-1:0];
            end else begin
                r_vspread <= pwdata[hndq_pkg::VSPR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == hndq_pkg::REG_TIM_SPREAD[2]) begin
            prdata = {{(hndq_pkg::DATA_W - hndq_pkg::TSPR_W){1'b0}}, r_tspread};
        end else begin
            prdata = {{(hndq_pkg::DATA_W - hndq_pkg::VSPR_W){1'b0}}, r_vspread};
        end
    end
    assign pready = 1'b1;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign cur      = (r_state == ST_IDLE) ? i_item : r_item;
    assign last_slot = (r_slot == SW'(PENDING_SLOTS - 1));
    // The spread times 48 as a sum of two shifts.
    assign maxd     = hndq_pkg::MOD_W'({r_tspread, 5'b0})
                    + hndq_pkg::MOD_W'({r_tspread, 4'b0});
    assign half_row = {1'b0, r_item.row_length[hndq_pkg::LEN_W-1:1]};
    assign dly      = (mod_rem > half_row) ? half_row : mod_rem;
    assign fire     = (r_item.frame_count >= r_rd.delay);
    assign fire_col = r_col[r_slot];
    assign vsum     = $signed({3'b000, r_vel}) + $signed({2'b00, mod_rem[7:0]})
                    - $signed({3'b000, r_vspread});

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int s = PENDING_SLOTS - 1; s >= 0; s--) begin
            if (!r_act[s]) begin
                found    = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_vel      = r_vel;
        n_slot     = r_slot;
        n_act      = r_act;
        n_col      = r_col;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_ready;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wa     = r_slot;
        mem_wd     = r_rd;
        mod_start  = 1'b0;
        mod_dvd    = cur.delay_draw;
        mod_dvs    = maxd + 1'b1;
        go_t       = 1'b0;
        vel_t      = cur.note_velocity;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    if (i_item.command == hndq_pkg::CMD_SCHEDULE ||
                        i_item.command == hndq_pkg::CMD_CANCEL) begin
                        for (int s = 0; s < PENDING_SLOTS; s++) begin
                            if (r_col[s] == i_item.column_id) n_act[s] = 1'b0;
                        end
                    end
                    if (i_item.command == hndq_pkg::CMD_SCHEDULE) begin
                        if (r_vspread != '0) begin
                            mod_start = 1'b1;
                            mod_dvd   = i_item.velocity_draw;
                            mod_dvs   = hndq_pkg::MOD_W'({r_vspread, 1'b0}) + 1'b1;
                            n_vel     = i_item.note_velocity;
                            n_state   = ST_VMOD;
                        end else begin
                            go_t = 1'b1;
                        end
                    end else if (i_item.command == hndq_pkg::CMD_ADVANCE) begin
                        n_slot  = '0;
                        n_state = ST_ARD;
                    end
                end
            end
            ST_VMOD: begin
                if (mod_done) begin
                    go_t = 1'b1;
                    if (vsum < 10'sd1) begin
                        vel_t = 7'd1;
                    end else if (vsum > 10'sd127) begin
                        vel_t = hndq_pkg::VEL_MAX;
                    end else begin
                        vel_t = vsum[hndq_pkg::VEL_W-1:0];
                    end
                end
            end
            ST_DMOD: begin
                if (mod_done) begin
                    if (found) begin
                        mem_we   = 1'b1;
                        mem_wa   = free_idx;
                        mem_wd   = '{note: r_item.note_number, vel: r_vel,
                                     smp: r_item.sample_slot, delay: dly};
                        n_act[free_idx] = 1'b1;
                        n_col[free_idx] = r_item.column_id;
                        n_state  = ST_IDLE;
                    end else begin
                        n_pend     = '{fired_note: r_item.note_number, fired_velocity: r_vel,
                                       fired_column: r_item.column_id,
                                       fired_sample: r_item.sample_slot, last_of_run: 1'b0};
                        n_pend_vld = 1'b1;
                        n_state    = ST_AEND;
                    end
                end
            end
            ST_ARD: begin
                if (r_act[r_slot]) begin
                    mem_re  = 1'b1;
                    n_state = ST_AEV;
                end else if (last_slot) begin
                    n_state = ST_AEND;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_AEV: begin
                if (!fire || !r_pend_vld || out_free) begin
                    if (fire) begin
                        if (r_pend_vld) begin
                            n_out     = r_pend;
                            n_out_vld = 1'b1;
                        end
                        n_pend     = '{fired_note: r_rd.note, fired_velocity: r_rd.vel,
                                       fired_column: fire_col, fired_sample: r_rd.smp,
                                       last_of_run: 1'b0};
                        n_pend_vld = 1'b1;
                        // A fired note also drops every other pending note of its column.
                        for (int s = 0; s < PENDING_SLOTS; s++) begin
                            if (r_col[s] == fire_col) n_act[s] = 1'b0;
                        end
                        n_act[r_slot] = 1'b0;
                    end else begin
                        mem_we       = 1'b1;
                        mem_wd.delay = r_rd.delay - r_item.frame_count;
                    end
                    if (last_slot) begin
                        n_state = ST_AEND;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = ST_ARD;
                    end
                end
            end
            ST_AEND: begin
                if (!r_pend_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out             = r_pend;
                    n_out.last_of_run = 1'b1;
                    n_out_vld         = 1'b1;
                    n_pend_vld        = 1'b0;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (go_t) begin
            n_vel = vel_t;
            if (r_tspread != '0) begin
                mod_start = 1'b1;
                mod_dvd   = cur.delay_draw;
                mod_dvs   = maxd + 1'b1;
                n_state   = ST_DMOD;
            end else begin
                n_pend     = '{fired_note: cur.note_number, fired_velocity: vel_t,
                               fired_column: cur.column_id, fired_sample: cur.sample_slot,
                               last_of_run: 1'b0};
                n_pend_vld = 1'b1;
                n_state    = ST_AEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_act      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_act      <= n_act;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_item <= n_item;
        r_vel  <= n_vel;
        r_slot <= n_slot;
        r_col  <= n_col;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[r_slot];
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    a_pend_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_pend_vld)
        else $error("held word left behind on return to idle");

    a_mod_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == ST_VMOD || r_state == ST_DMOD))
        else $error("remainder finished while nobody waited");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_act == '0 && !r_out_vld))
        else $error("slots not empty after reset");
endmodule
